@@ rtl/blz_pkg.sv @@
// ----------------------------------------------------------------------------
// blz_pkg
// Shared types, constants and controller/datapath links for the backward LZ
// bitstream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package blz_pkg;

  localparam int unsigned WindowDepthDefault = 32768;
  localparam int unsigned BufferBitsDefault  = 32;

  localparam int unsigned LenW = 24;
  localparam int unsigned OffW = 15;
  localparam logic [LenW-1:0] RunMax = {LenW{1'b1}};

  // transaction modes
  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_PULL   = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // result codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_BYTE   = 3'd2;
  localparam logic [2:0] ST_NEED   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;
  localparam logic [2:0] ST_BADOFF = 3'd5;

  // register indexes
  localparam logic [2:0] REG_OW0  = 3'd0;
  localparam logic [2:0] REG_OW1  = 3'd1;
  localparam logic [2:0] REG_OW2  = 3'd2;
  localparam logic [2:0] REG_OW3  = 3'd3;
  localparam logic [2:0] REG_OLEN = 3'd4;
  localparam logic [2:0] REG_SKIP = 3'd5;

  // decode phases
  localparam logic [3:0] PH_SKIP     = 4'd0;
  localparam logic [3:0] PH_FLAG     = 4'd1;
  localparam logic [3:0] PH_LITLEN   = 4'd2;
  localparam logic [3:0] PH_LITBYTE  = 4'd3;
  localparam logic [3:0] PH_COPYSEL  = 4'd4;
  localparam logic [3:0] PH_COPYESC  = 4'd5;
  localparam logic [3:0] PH_COPYOFF  = 4'd6;
  localparam logic [3:0] PH_COPYOFF7 = 4'd7;
  localparam logic [3:0] PH_COPYLEN  = 4'd8;
  localparam logic [3:0] PH_COPYBYTE = 4'd9;
  localparam logic [3:0] PH_DONE     = 4'd10;
  localparam logic [3:0] PH_ERROR    = 4'd11;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       is_last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       push;      // append in_byte to bit buffer
    logic       start;     // clear stream state
    logic       step;      // execute one decode step of current phase
    logic       hist_rd;   // issue history read for copy byte
    logic       emit_copy; // emit registered history byte
    logic       finish;    // park the stream in the finished phase
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       full;
    logic [3:0] phase;
    logic       done;       // produced >= output_length
    logic       short_bits; // current phase lacks bits
    logic       bad_off;    // copy offset out of range
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/blz_ram.sv @@
// ----------------------------------------------------------------------------
// blz_ram
// Single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module blz_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/blz_datapath.sv @@
// ----------------------------------------------------------------------------
// blz_datapath
// Bit buffer, decode counters, configuration registers and history window.
// ----------------------------------------------------------------------------
`default_nettype none

module blz_datapath
  import blz_pkg::*;
#(
  parameter int unsigned WindowDepth = WindowDepthDefault,
  parameter int unsigned BufferBits  = BufferBitsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [23:0] cfg_data,
  input  wire logic [7:0] in_byte,
  input  wire dp_cmd_t   cmd,
  output dp_stat_t       stat,
  output logic [7:0]     emit_byte,
  output logic           emit_last
);

  localparam int unsigned AW = $clog2(WindowDepth);
  localparam int unsigned HW = $clog2(BufferBits + 1);

  logic [3:0]  ow [4];
  logic [23:0] olen;
  logic [4:0]  skip;

  logic [BufferBits-1:0] bitbuf;
  logic [HW-1:0]         held;
  logic [3:0]            phase;
  logic [LenW-1:0]       run_left;
  logic [1:0]            sel;
  logic [OffW-1:0]       offset;
  logic [LenW-1:0]       produced;

  always_ff @(posedge clk) begin
    if (rst) begin
      ow[0] <= 4'd9;
      ow[1] <= 4'd10;
      ow[2] <= 4'd12;
      ow[3] <= 4'd13;
      olen  <= 24'd1;
      skip  <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OW0:  ow[0] <= cfg_data[3:0];
        REG_OW1:  ow[1] <= cfg_data[3:0];
        REG_OW2:  ow[2] <= cfg_data[3:0];
        REG_OW3:  ow[3] <= cfg_data[3:0];
        REG_OLEN: olen  <= cfg_data;
        REG_SKIP: skip  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // bits needed by the current phase
  logic [3:0] need;
  always_comb begin
    unique case (phase)
      PH_SKIP:     need = (run_left >= {19'd0, skip}) ? 4'd0 : 4'd1;
      PH_FLAG:     need = 4'd1;
      PH_LITLEN:   need = 4'd2;
      PH_LITBYTE:  need = 4'd8;
      PH_COPYSEL:  need = 4'd2;
      PH_COPYESC:  need = 4'd1;
      PH_COPYOFF:  need = ow[sel];
      PH_COPYOFF7: need = 4'd7;
      PH_COPYLEN:  need = 4'd3;
      default:     need = 4'd0;
    endcase
  end

  // first bit taken becomes MSB: bit-reverse the low 15 bits, then align
  logic [14:0] rev;
  logic [14:0] val;
  always_comb begin
    for (int i = 0; i < 15; i++) begin
      rev[i] = bitbuf[14 - i];
    end
    val = rev >> (4'd15 - need);
    if (need == 4'd0) begin
      val = '0;
    end
  end

  logic short_bits;
  assign short_bits = {{(HW > 4 ? HW-4 : 0){1'b0}}, need} > held;

  logic done;
  assign done = produced >= olen;

  logic [LenW:0] run_sum;
  logic [LenW-1:0] run_sat;
  assign run_sum = {1'b0, run_left} + {{(LenW-2){1'b0}}, val[2:0]};
  assign run_sat = run_sum[LenW] ? RunMax : run_sum[LenW-1:0];

  // history
  logic [7:0]    hist_q;
  logic          hist_we;
  logic [7:0]    hist_wd;
  logic [LenW-1:0] rd_pos;
  assign rd_pos = produced - 24'd1 - {9'd0, offset};

  blz_ram #(.Width(8), .Depth(WindowDepth)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (produced[AW-1:0]),
    .wdata (hist_wd),
    .re    (cmd.hist_rd),
    .raddr (rd_pos[AW-1:0]),
    .rdata (hist_q)
  );

  logic emitting;
  assign emitting = (cmd.step && phase == PH_LITBYTE) || cmd.emit_copy;
  assign hist_wd  = cmd.emit_copy ? hist_q : val[7:0];
  assign hist_we  = emitting;
  assign emit_byte = hist_wd;
  assign emit_last = (produced + 24'd1) >= olen;

  logic [LenW-1:0] run_dec;
  assign run_dec = (run_left != '0) ? run_left - 24'd1 : run_left;

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      bitbuf   <= '0;
      held     <= '0;
      phase    <= PH_SKIP;
      run_left <= '0;
      sel      <= '0;
      offset   <= '0;
      produced <= '0;
    end else if (cmd.push) begin
      bitbuf <= bitbuf | ({{(BufferBits-8){1'b0}}, in_byte} << held);
      held   <= held + HW'(8);
    end else if (emitting) begin
      if (phase == PH_LITBYTE) begin
        bitbuf <= bitbuf >> 8;
        held   <= held - HW'(8);
      end
      produced <= produced + 24'd1;
      run_left <= run_dec;
      if (emit_last) begin
        phase <= PH_DONE;
      end else if (run_dec == '0) begin
        phase <= (phase == PH_LITBYTE) ? PH_COPYSEL : PH_FLAG;
      end
    end else if (cmd.step) begin
      bitbuf <= bitbuf >> need;
      held   <= held - HW'(need);
      unique case (phase)
        PH_SKIP: begin
          if (need == 4'd0) begin
            run_left <= '0;
            phase    <= PH_FLAG;
          end else begin
            run_left <= run_left + 24'd1;
          end
        end
        PH_FLAG: begin
          if (val[0] == 1'b0) begin
            run_left <= 24'd1;
            phase    <= PH_LITLEN;
          end else begin
            phase <= PH_COPYSEL;
          end
        end
        PH_LITLEN: begin
          run_left <= run_sat;
          if (val[1:0] != 2'd3) phase <= PH_LITBYTE;
        end
        PH_COPYSEL: begin
          sel      <= val[1:0];
          run_left <= {22'd0, val[1:0]} + 24'd2;
          phase    <= (val[1:0] == 2'd3) ? PH_COPYESC : PH_COPYOFF;
        end
        PH_COPYESC: phase <= val[0] ? PH_COPYOFF : PH_COPYOFF7;
        PH_COPYOFF, PH_COPYOFF7: begin
          offset <= val;
          phase  <= (sel == 2'd3) ? PH_COPYLEN : PH_COPYBYTE;
        end
        PH_COPYLEN: begin
          run_left <= run_sat;
          if (val[2:0] != 3'd7) phase <= PH_COPYBYTE;
        end
        PH_COPYBYTE: phase <= PH_ERROR;  // only stepped on bad offset
        PH_DONE:     phase <= PH_DONE;
        default:     phase <= PH_ERROR;
      endcase
    end else if (cmd.finish) begin
      // stay finished even if output_length is raised later
      phase <= PH_DONE;
    end
  end

  assign stat.full       = ({1'b0, held} + (HW+1)'(8)) > (HW+1)'(BufferBits);
  assign stat.phase      = phase;
  assign stat.done       = done;
  assign stat.short_bits = short_bits;
  assign stat.bad_off    = {9'd0, offset} >= produced;

endmodule

`default_nettype wire

@@ rtl/blz_ctrl.sv @@
// ----------------------------------------------------------------------------
// blz_ctrl
// Transaction sequencer: walks decode steps for a pull until a result is
// known, then holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blz_ctrl
  import blz_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic [1:0] mode,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item,
  output dp_cmd_t        cmd,
  input  wire dp_stat_t  stat,
  input  wire logic [7:0] emit_byte,
  input  wire logic      emit_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_COPY = 2'd3;

  logic [1:0] state, state_next;
  out_item_t  res_next;
  logic       res_load;

  logic take;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign take     = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    res_next   = '0;
    res_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          unique case (mode)
            MODE_PUSH: begin
              res_load = 1'b1;
              if (stat.full) res_next.status = ST_FULL;
              else cmd.push = 1'b1;
            end
            MODE_PULL: state_next = S_RUN;
            MODE_START: begin
              cmd.start = 1'b1;
              res_load  = 1'b1;
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      S_RUN: begin
        if (stat.phase == PH_ERROR) begin
          res_next.status = ST_BADOFF;
          res_load = 1'b1;
        end else if (stat.phase == PH_DONE || stat.done) begin
          cmd.finish = 1'b1;
          res_next.status = ST_DONE;
          res_load = 1'b1;
        end else if (stat.phase == PH_COPYBYTE) begin
          if (stat.bad_off) begin
            cmd.step = 1'b1;  // moves to error
            res_next.status = ST_BADOFF;
            res_load = 1'b1;
          end else begin
            cmd.hist_rd = 1'b1;
            state_next  = S_READ;
          end
        end else if (stat.short_bits) begin
          res_next.status = ST_NEED;
          res_load = 1'b1;
        end else begin
          cmd.step = 1'b1;
          if (stat.phase == PH_LITBYTE) begin
            res_next.status   = ST_BYTE;
            res_next.out_byte = emit_byte;
            res_next.is_last  = emit_last;
            res_load = 1'b1;
          end
        end
        if (res_load) state_next = S_IDLE;
      end
      S_READ: state_next = S_COPY;
      S_COPY: begin
        cmd.emit_copy     = 1'b1;
        res_next.status   = ST_BYTE;
        res_next.out_byte = emit_byte;
        res_next.is_last  = emit_last;
        res_load          = 1'b1;
        state_next        = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_item <= res_next;
  end

endmodule

`default_nettype wire

@@ rtl/backward_lz_bitstream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// backward_lz_bitstream_decoder_unit
// Backward LZ decoder: compressed bytes pushed from the stream end, output
// bytes pulled one per transaction from the last position backward.
// ----------------------------------------------------------------------------
// Usage: each input transaction (valid/ready) carries a mode: push a byte,
// pull one output byte, or start a new stream. Every input transaction
// returns exactly one result transaction holding status, out_byte, is_last.
// Push, start and unused modes raise out_valid at the accepting edge. A pull
// walks its decode steps before out_valid rises: only the byte step for a
// literal inside a run; flag, length and byte steps for the first literal of
// a run, plus one per extra length group; for a copy byte the offset check,
// registered history read and emit, plus one step per header field still to
// parse. The first pull of a stream also walks one skip step per skipped bit
// and a final one. Need-input, finished and bad-offset answers are loaded by
// the run-state status check. One transaction is in flight at a time; the
// next is taken the cycle after the result is accepted. A stalled receiver
// holds the result and blocks new input.
// Reset clears the bit buffer and counters and loads the register defaults;
// the history window needs no clearing. Configuration writes are taken at
// any time and should be issued while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module backward_lz_bitstream_decoder_unit
  import blz_pkg::*;
#(
  parameter int unsigned WindowDepth = WindowDepthDefault,
  parameter int unsigned BufferBits  = BufferBitsDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [23:0] cfg_value
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [7:0] emit_byte;
  logic       emit_last;

  assign cfg_ready = 1'b1;

  blz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (in_data.mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data),
    .cmd       (cmd),
    .stat      (stat),
    .emit_byte (emit_byte),
    .emit_last (emit_last)
  );

  blz_datapath #(.WindowDepth(WindowDepth), .BufferBits(BufferBits)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_data  (cfg_value),
    .in_byte   (in_data.in_byte),
    .cmd       (cmd),
    .stat      (stat),
    .emit_byte (emit_byte),
    .emit_last (emit_last)
  );

endmodule

`default_nettype wire
